### sv/sisb_pkg.sv
// shared types and field widths of the stable insertion sort buffer
package sisb_pkg;

    localparam int POS_W   = 32;
    localparam int TAG_W   = 6;
    localparam int FIX_W   = 6;
    localparam int SHIFT_W = 11;

    // one sorted record as held by a cell
    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic [TAG_W-1:0]        tag;
    } entry_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic load;   // insert the broadcast record
        logic drain;  // move every entry one cell toward the head
    } cell_cmd_t;

endpackage

### sv/sisb_cell.sv
// one cell of the sorted chain: holds an entry, compares, shifts
module sisb_cell
    import sisb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  entry_t    new_entry,
    input  entry_t    prev_entry,
    input  logic      prev_valid,
    input  logic      prev_gt,
    input  entry_t    next_entry,
    input  logic      next_valid,
    output entry_t    entry,
    output logic      valid,
    output logic      gt
);

    entry_t entry_reg;
    logic   valid_reg;
    logic   take;

    // held entry sorts after the incoming record
    assign gt = valid_reg && (entry_reg.pos > new_entry.pos);

    // shifted cells and the first empty cell take a new entry
    assign take = gt || (!valid_reg && prev_valid);

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.drain)
        begin
            valid_reg <= next_valid;
        end
        else if (cmd.load && take)
        begin
            valid_reg <= 1'b1;
        end
    end

    // payload: next cell on drain, prior cell on shift, else new record
    always_ff @(posedge clk)
    begin
        if (cmd.drain)
        begin
            entry_reg <= next_entry;
        end
        else if (cmd.load && take)
        begin
            entry_reg <= prev_gt ? prev_entry : new_entry;
        end
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

### sv/sisb_counter.sv
// fill level, out-of-order count and shift (inversion) count
module sisb_counter
    import sisb_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic                       clear,
    input  logic [DEPTH-1:0]           le,
    output logic [$clog2(DEPTH+1)-1:0] fill,
    output logic                       full,
    output logic [FIX_W-1:0]           fix_count,
    output logic [SHIFT_W-1:0]         shift_total
);

    localparam int CW = $clog2(DEPTH+1);

    logic [CW-1:0]      fill_reg;
    logic [FIX_W-1:0]   fix_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [CW-1:0]      slot;
    logic [CW-1:0]      shifts;

    // le is a run of ones from the head; its end gives the insertion slot
    always_comb
    begin
        slot = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (le[i] && ((i == DEPTH-1) || !le[(i+1) % DEPTH]))
            begin
                slot = slot | CW'(i + 1);
            end
        end
    end

    assign shifts = fill_reg - slot;

    // counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            fix_reg   <= '0;
            shift_reg <= '0;
        end
        else if (clear)
        begin
            fill_reg  <= '0;
            fix_reg   <= '0;
            shift_reg <= '0;
        end
        else if (load)
        begin
            fill_reg <= fill_reg + 1'b1;
            if (shifts != '0)
            begin
                fix_reg   <= fix_reg + 1'b1;
                shift_reg <= shift_reg + SHIFT_W'(shifts);
            end
        end
    end

    assign fill        = fill_reg;
    assign full        = (fill_reg == CW'(DEPTH));
    assign fix_count   = fix_reg;
    assign shift_total = shift_reg;

endmodule

### sv/stable_insertion_sort_buffer.sv
// stable insertion sort buffer: top level with the cell chain and drain control
// load: one record per cycle unless stalled, inserted by parallel compare and shift
// across the chain; drain: after the last record, one sorted entry per cycle from the
// head cell while out_stall is low, the first in the cycle after the last record;
// input is stalled for the whole drain; a new load starts after the final beat
// reset (async, active low) empties every cell and clears all counters
module stable_insertion_sort_buffer
    import sisb_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [POS_W-1:0]  new_position,
    input  logic [TAG_W-1:0]         record_tag,
    input  logic                     last_item,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [POS_W-1:0]  sorted_position,
    output logic [TAG_W-1:0]         sorted_tag,
    output logic                     last_result,
    output logic [FIX_W-1:0]         out_of_order_count,
    output logic [SHIFT_W-1:0]       shift_count
);

    localparam int CW = $clog2(DEPTH+1);

    logic               drain_reg;
    logic               in_beat;
    logic               out_beat;
    logic               final_beat;
    logic               full;
    logic [CW-1:0]      fill;
    logic [FIX_W-1:0]   fix_count;
    logic [SHIFT_W-1:0] shift_total;
    cell_cmd_t          cmd;
    entry_t             new_entry;
    entry_t             entry [DEPTH];
    logic [DEPTH-1:0]   valid_vec;
    logic [DEPTH-1:0]   gt_vec;
    logic [DEPTH-1:0]   le_vec;

    assign in_stall   = drain_reg;
    assign in_beat    = in_valid && !in_stall;
    assign out_valid  = drain_reg && valid_vec[0];
    assign out_beat   = out_valid && !out_stall;
    assign final_beat = out_beat && last_result;

    assign new_entry.pos = new_position;
    assign new_entry.tag = record_tag;

    assign cmd.load  = in_beat && !full;
    assign cmd.drain = out_beat;

    // chain of cells, head at index 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t prev_e;
        logic   prev_v;
        logic   prev_g;
        entry_t next_e;
        logic   next_v;

        if (i == 0)
        begin : g_head
            assign prev_e = new_entry;
            assign prev_v = 1'b1;
            assign prev_g = 1'b0;
        end
        else
        begin : g_body
            assign prev_e = entry[i-1];
            assign prev_v = valid_vec[i-1];
            assign prev_g = gt_vec[i-1];
        end

        if (i == DEPTH-1)
        begin : g_tail
            assign next_e = new_entry;
            assign next_v = 1'b0;
        end
        else
        begin : g_inner
            assign next_e = entry[i+1];
            assign next_v = valid_vec[i+1];
        end

        sisb_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .new_entry  (new_entry),
            .prev_entry (prev_e),
            .prev_valid (prev_v),
            .prev_gt    (prev_g),
            .next_entry (next_e),
            .next_valid (next_v),
            .entry      (entry[i]),
            .valid      (valid_vec[i]),
            .gt         (gt_vec[i])
        );
    end

    assign le_vec = valid_vec & ~gt_vec;

    sisb_counter #(
        .DEPTH (DEPTH)
    ) u_counter (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (cmd.load),
        .clear       (final_beat),
        .le          (le_vec),
        .fill        (fill),
        .full        (full),
        .fix_count   (fix_count),
        .shift_total (shift_total)
    );

    // drain mode from the last record until the final beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg <= 1'b0;
        end
        else if (final_beat)
        begin
            drain_reg <= 1'b0;
        end
        else if (in_beat && last_item)
        begin
            drain_reg <= 1'b1;
        end
    end

    // output beat from the head cell
    assign sorted_position    = entry[0].pos;
    assign sorted_tag         = entry[0].tag;
    assign last_result        = !valid_vec[1];
    assign out_of_order_count = last_result ? fix_count : '0;
    assign shift_count        = last_result ? shift_total : '0;

    // no record is taken while sorted entries are pending
    a_no_load_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted during drain");

    // occupied cells form one run from the head
    a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + 1'b1) & valid_vec) == '0)
        else $error("gap in occupied cells");

    // fill level matches occupied cells while loading
    a_fill_match: assert property (@(posedge clk) disable iff (!rst_n)
        !drain_reg |-> ($countones(valid_vec) == fill))
        else $error("fill count out of step with cells");

    // the chain is empty after the final beat
    a_empty_after: assert property (@(posedge clk) disable iff (!rst_n)
        final_beat |=> (valid_vec == '0) && !out_valid && (fill == '0))
        else $error("chain not empty after final beat");

endmodule
